// File: hdl/swrg_pkg.sv
package swrg_pkg;

    // Input item modes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SLEEP = 2'd1;
    localparam logic [1:0] MODE_EDGE  = 2'd2;
    localparam logic [1:0] MODE_WAKE  = 2'd3;

    // Switch classes, also the reported event codes
    localparam logic [1:0] CLASS_ON   = 2'd0;
    localparam logic [1:0] CLASS_OFF  = 2'd1;
    localparam logic [1:0] CLASS_BOOT = 2'd2;

    // Configuration register indexes
    localparam logic CFG_QUIET_SAMPLES    = 1'b0;
    localparam logic CFG_TOGGLE_THRESHOLD = 1'b1;

    localparam logic [7:0] QUIET_SAMPLES_RST    = 8'd14;
    localparam logic [7:0] TOGGLE_THRESHOLD_RST = 8'd6;
    localparam logic [7:0] COUNT_MAX            = 8'd255;

    typedef struct packed {
        logic [1:0] mode;
        logic       pin_level;
    } t_in_item;

    typedef struct packed {
        logic       event_valid;
        logic [1:0] event_code;
        logic       wake_notify;
    } t_out_item;

endpackage

// File: hdl/switch_rocking_gesture_detector.sv
// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_ready | i_in  (mode, pin_level)
// out     | output    | o_out_valid/ i_out_ready| o_out (event_valid, event_code, wake_notify)
// cfg     | input     | i_cfg_valid/ o_cfg_ready| i_cfg_index, i_cfg_data
//
// Each item's result is computed from the item and the gesture state
// and lands in the output register at the accepting edge.
// One result per item; items are accepted back to back while the output
// register is empty or being drained in the same cycle.
// A stalled output holds the result and blocks input only while it stays full.
// Reset (synchronous, active low) restores the register defaults and the
// idle gesture state; the config port is always ready.
module switch_rocking_gesture_detector (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  swrg_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output swrg_pkg::t_out_item  o_out,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data
);
    import swrg_pkg::*;

    // Configuration registers
    logic [7:0] r_quiet_samples;
    logic [7:0] r_toggle_threshold;

    // Gesture state; the current class always equals the last reported one
    // once an item finishes, so one register holds both.
    logic       r_prior_level,    n_prior_level;
    logic [7:0] r_change_count,   n_change_count;
    logic [7:0] r_quiet_count,    n_quiet_count;
    logic [1:0] r_reported_class, n_reported_class;
    logic       r_asleep,         n_asleep;
    logic       r_skip_next_edge, n_skip_next_edge;
    logic       r_edge_passed,    n_edge_passed;
    logic       r_wake_notified,  n_wake_notified;

    // Output register
    logic       r_out_valid;
    t_out_item  r_out;
    t_out_item  n_out;

    logic       in_fire;
    logic [7:0] tick_change;
    logic [7:0] tick_quiet;
    logic [1:0] tick_class;
    logic       tick_classify;

    // Accept while the output slot is empty or drains this cycle
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Sample tick counting: a level change bumps the change count and
    // restarts the quiet count, a steady sample extends the quiet count.
    always_comb begin
        tick_change = r_change_count;
        tick_quiet  = r_quiet_count;
        if (i_in.pin_level != r_prior_level) begin
            if (r_change_count != COUNT_MAX) begin
                tick_change = r_change_count + 8'd1;
            end
            tick_quiet = '0;
        end else if (r_quiet_count != COUNT_MAX) begin
            tick_quiet = r_quiet_count + 8'd1;
        end
        tick_classify = (tick_quiet >= r_quiet_samples);
        if (tick_change >= r_toggle_threshold) begin
            tick_class = CLASS_BOOT;
        end else if (i_in.pin_level) begin
            tick_class = CLASS_OFF;
        end else begin
            tick_class = CLASS_ON;
        end
    end

    always_comb begin
        n_prior_level    = r_prior_level;
        n_change_count   = r_change_count;
        n_quiet_count    = r_quiet_count;
        n_reported_class = r_reported_class;
        n_asleep         = r_asleep;
        n_skip_next_edge = r_skip_next_edge;
        n_edge_passed    = r_edge_passed;
        n_wake_notified  = r_wake_notified;
        n_out            = '0;

        case (i_in.mode)
            MODE_TICK: begin
                // Drop ticks while asleep
                if (!r_asleep) begin
                    n_change_count = tick_change;
                    n_quiet_count  = tick_quiet;
                    if (tick_classify) begin
                        n_change_count = '0;
                        if (tick_class != r_reported_class) begin
                            n_out.event_valid = 1'b1;
                            n_out.event_code  = tick_class;
                            n_reported_class  = tick_class;
                        end
                    end
                    n_prior_level = i_in.pin_level;
                end
            end
            MODE_SLEEP: begin
                // Arm edge wake-up; the first edge is skipped
                n_asleep         = 1'b1;
                n_skip_next_edge = 1'b1;
                n_edge_passed    = 1'b0;
                n_wake_notified  = 1'b0;
            end
            MODE_EDGE: begin
                if (r_asleep) begin
                    if (r_skip_next_edge) begin
                        n_skip_next_edge = 1'b0;
                    end else if (!r_edge_passed) begin
                        n_edge_passed     = 1'b1;
                        n_asleep          = 1'b0;
                        n_wake_notified   = 1'b1;
                        n_out.wake_notify = !r_wake_notified;
                    end
                end
            end
            MODE_WAKE: begin
                n_asleep          = 1'b0;
                n_wake_notified   = 1'b1;
                n_out.wake_notify = !r_wake_notified;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quiet_samples    <= QUIET_SAMPLES_RST;
            r_toggle_threshold <= TOGGLE_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_QUIET_SAMPLES:    r_quiet_samples    <= i_cfg_data;
                CFG_TOGGLE_THRESHOLD: r_toggle_threshold <= i_cfg_data;
                default: begin
                    r_quiet_samples <= r_quiet_samples;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior_level    <= 1'b1;
            r_change_count   <= '0;
            r_quiet_count    <= '0;
            r_reported_class <= CLASS_ON;
            r_asleep         <= 1'b0;
            r_skip_next_edge <= 1'b0;
            r_edge_passed    <= 1'b0;
            r_wake_notified  <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            if (in_fire) begin
                r_prior_level    <= n_prior_level;
                r_change_count   <= n_change_count;
                r_quiet_count    <= n_quiet_count;
                r_reported_class <= n_reported_class;
                r_asleep         <= n_asleep;
                r_skip_next_edge <= n_skip_next_edge;
                r_edge_passed    <= n_edge_passed;
                r_wake_notified  <= n_wake_notified;
                r_out_valid      <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_code_zero_when_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.event_valid) |-> (r_out.event_code == CLASS_ON))
        else $error("event_code set without an event");

    a_code_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_valid) |->
        (r_out.event_code == CLASS_ON || r_out.event_code == CLASS_OFF ||
         r_out.event_code == CLASS_BOOT))
        else $error("illegal event code");

    a_event_xor_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.event_valid && r_out.wake_notify))
        else $error("event and wake notification in one item");

    a_asleep_tick_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_asleep && i_in.mode == MODE_TICK) |=>
        ($stable(r_change_count) && $stable(r_quiet_count) && !r_out.event_valid))
        else $error("tick changed state while asleep");

    a_sleep_arms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.mode == MODE_SLEEP) |=>
        (r_asleep && r_skip_next_edge && !r_wake_notified))
        else $error("sleep request did not arm wake-up");
`endif

endmodule
